### design/hdl_keyword_tokenizer_macros.svh
// ---------------------------------------------------------------------------
// hdl keyword tokenizer assertion macros
// shared concurrent assertion forms, clocked on clk_i, off during reset
// ---------------------------------------------------------------------------
`ifndef HDL_KEYWORD_TOKENIZER_MACROS_SVH
`define HDL_KEYWORD_TOKENIZER_MACROS_SVH

// property holds at every edge outside reset
`define HKT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition never seen outside reset
`define HKT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

### design/hkt_pkg.sv
// ---------------------------------------------------------------------------
// hkt_pkg
// shared types, token kinds and keyword table of the keyword tokenizer
// ---------------------------------------------------------------------------
package hkt_pkg;

  localparam int unsigned BufferBytesDef = 65536;
  localparam int unsigned MaxTokenLenDef = 255;
  localparam int unsigned NumKw          = 16;
  localparam int unsigned FifoDepth      = 4;

  localparam logic [4:0] K_CHAR    = 5'd0;
  localparam logic [4:0] K_IDENT   = 5'd1;
  localparam logic [4:0] K_NUMBER  = 5'd2;
  localparam logic [4:0] K_LITERAL = 5'd3;
  localparam logic [4:0] K_STRING  = 5'd4;
  localparam logic [4:0] K_EOF     = 5'd5;
  localparam logic [4:0] K_LOR     = 5'd6;
  localparam logic [4:0] K_LAND    = 5'd7;
  localparam logic [4:0] K_LTE     = 5'd8;
  localparam logic [4:0] K_LSH     = 5'd9;
  localparam logic [4:0] K_GTE     = 5'd10;
  localparam logic [4:0] K_RSH     = 5'd11;
  localparam logic [4:0] K_EQ      = 5'd12;
  localparam logic [4:0] K_KW0     = 5'd13;
  localparam logic [4:0] K_INVALID = 5'd29;

  localparam logic [3:0] KW_LEN [NumKw] = '{
    4'd6, 4'd9, 4'd4, 4'd3, 4'd6, 4'd7, 4'd5, 4'd3,
    4'd2, 4'd4, 4'd6, 4'd5, 4'd6, 4'd7, 4'd7, 4'd2
  };

  localparam logic [71:0] KW_TEXT [NumKw] = '{
    72'("module"), 72'("endmodule"), 72'("wire"), 72'("reg"),
    72'("always"), 72'("initial"), 72'("begin"), 72'("end"),
    72'("if"), 72'("else"), 72'("assign"), 72'("input"),
    72'("output"), 72'("posedge"), 72'("negedge"), 72'("or")
  };

  typedef struct packed {
    logic [4:0]  kind;
    logic [7:0]  ch;
    logic [15:0] start;
    logic [7:0]  len;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } step_t;

  // character at position pos of keyword idx, zero past its end
  function automatic logic [7:0] kw_char(logic [3:0] idx, logic [3:0] pos);
    logic [71:0] al;
    logic [3:0]  klen;
    klen = KW_LEN[idx];
    al = KW_TEXT[idx] << (7'd8 * (7'd9 - 7'(klen)));
    kw_char = 8'h00;
    if (pos < klen) begin
      kw_char = 8'(al >> (7'd8 * (7'd8 - 7'(pos))));
    end
  endfunction

endpackage

### design/hkt_lexer.sv
// ---------------------------------------------------------------------------
// hkt_lexer
// scanner state and single-pass next-state logic, up to two tokens per byte
// ---------------------------------------------------------------------------
module hkt_lexer import hkt_pkg::*; #(
  parameter int unsigned BufferBytes = BufferBytesDef,
  parameter int unsigned MaxTokenLen = MaxTokenLenDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       fire_i,
  input  logic [7:0] byte_i,
  input  logic       eoi_i,
  output step_t      step_o
);

  localparam int unsigned OffW = $clog2(BufferBytes + 1);
  localparam int unsigned LenW = $clog2(MaxTokenLen + 1);

  typedef enum logic [6:0] {
    PhIdle   = 7'b0000001,
    PhIdent  = 7'b0000010,
    PhNumber = 7'b0000100,
    PhBase   = 7'b0001000,
    PhLitDig = 7'b0010000,
    PhString = 7'b0100000,
    PhOp     = 7'b1000000
  } phase_e;

  localparam logic [7:0] ChQuote  = 8'h27;
  localparam logic [7:0] ChDquote = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChUscore = 8'h5F;
  localparam logic [7:0] ChB      = 8'h62;
  localparam logic [7:0] ChO      = 8'h6F;
  localparam logic [7:0] ChD      = 8'h64;
  localparam logic [7:0] ChH      = 8'h68;

  phase_e            phase_q, phase_d;
  logic [OffW-1:0]   offset_q, offset_d;
  logic [15:0]       start_q, start_d;
  logic [LenW-1:0]   len_q, len_d, len_inc;
  logic [NumKw-1:0]  cand_q, cand_d, cmatch, mask0;
  logic [7:0]        fsc_q, fsc_d;
  logic [1:0]        base_q, base_d;
  logic              esc_q, esc_d;
  logic              is_end;
  logic [4:0]        ident_kind;

  function automatic logic is_digit(logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

  function automatic logic base_digit(logic [1:0] b, logic [7:0] c);
    logic r;
    case (b)
      2'd0:    r = (c == "0") || (c == "1");
      2'd1:    r = (c >= "0") && (c <= "7");
      2'd2:    r = is_digit(c);
      default: r = is_digit(c) || ((c >= "a") && (c <= "f")) || ((c >= "A") && (c <= "F"));
    endcase
    return r;
  endfunction

  function automatic logic [4:0] pair_kind(logic [7:0] a, logic [7:0] b);
    logic [4:0] k;
    k = K_CHAR;
    if (a == "|" && b == "|") k = K_LOR;
    else if (a == "&" && b == "&") k = K_LAND;
    else if (a == "<" && b == "=") k = K_LTE;
    else if (a == "<" && b == "<") k = K_LSH;
    else if (a == ">" && b == "=") k = K_GTE;
    else if (a == ">" && b == ">") k = K_RSH;
    else if (a == "=" && b == "=") k = K_EQ;
    return k;
  endfunction

  function automatic logic [7:0] sat8(logic [LenW-1:0] l);
    if (32'(l) > 32'd255) return 8'hFF;
    return 8'(l);
  endfunction

  function automatic res_t mk(logic [4:0] kind, logic [7:0] ch, logic [15:0] start,
                              logic [7:0] len);
    res_t r;
    r.kind  = kind;
    r.ch    = ch;
    r.start = start;
    r.len   = len;
    r.last  = 1'b0;
    return r;
  endfunction

  assign is_end  = eoi_i || (byte_i == 8'h00) || (offset_q >= OffW'(BufferBytes));
  assign len_inc = (32'(len_q) < MaxTokenLen) ? len_q + LenW'(1) : len_q;

  always_comb begin
    for (int i = 0; i < NumKw; i++) begin
      cmatch[i] = (32'(len_q) < 32'(KW_LEN[i])) && (kw_char(4'(i), len_q[3:0]) == byte_i);
      mask0[i]  = (kw_char(4'(i), 4'd0) == byte_i);
    end
  end

  // lowest matching keyword wins
  always_comb begin
    ident_kind = K_IDENT;
    for (int i = NumKw - 1; i >= 0; i--) begin
      if (cand_q[i] && (32'(len_q) == 32'(KW_LEN[i]))) begin
        ident_kind = K_KW0 + 5'(i);
      end
    end
  end

  logic emit_a, emit_b, go_idle;
  res_t res_a, res_b;
  logic [4:0] pk;

  always_comb begin
    phase_d  = phase_q;
    offset_d = offset_q;
    start_d  = start_q;
    len_d    = len_q;
    cand_d   = cand_q;
    fsc_d    = fsc_q;
    base_d   = base_q;
    esc_d    = esc_q;
    emit_a   = 1'b0;
    emit_b   = 1'b0;
    res_a    = '0;
    res_b    = '0;
    go_idle  = 1'b0;
    pk       = pair_kind(fsc_q, byte_i);
    if (is_end) begin
      unique case (phase_q)
        PhIdent: begin
          emit_a = 1'b1;
          res_a  = mk(ident_kind, 8'h00, start_q, sat8(len_q));
        end
        PhNumber: begin
          emit_a = 1'b1;
          res_a  = mk(K_NUMBER, 8'h00, start_q, sat8(len_q));
        end
        PhBase: begin
          emit_a = 1'b1;
          res_a  = mk(K_INVALID, 8'h00, start_q, sat8(len_q));
        end
        PhLitDig: begin
          emit_a = 1'b1;
          res_a  = mk(K_LITERAL, 8'h00, start_q, sat8(len_q));
        end
        PhString: begin
          emit_a = 1'b1;
          res_a  = mk(K_STRING, 8'h00, start_q, sat8(len_q));
        end
        PhOp: begin
          emit_a = 1'b1;
          res_a  = mk(K_CHAR, fsc_q, start_q, 8'd1);
        end
        default: ;
      endcase
      emit_b   = 1'b1;
      res_b    = mk(K_EOF, 8'h00, 16'(offset_q), 8'd0);
      phase_d  = PhIdle;
      offset_d = '0;
      start_d  = '0;
      len_d    = '0;
      cand_d   = '1;
      fsc_d    = '0;
      base_d   = '0;
      esc_d    = 1'b0;
    end else begin
      offset_d = offset_q + OffW'(1);
      unique case (phase_q)
        PhIdent: begin
          if (is_alpha(byte_i) || is_digit(byte_i) || byte_i == ChUscore) begin
            cand_d = cand_q & cmatch;
            len_d  = len_inc;
          end else begin
            emit_a  = 1'b1;
            res_a   = mk(ident_kind, 8'h00, start_q, sat8(len_q));
            go_idle = 1'b1;
          end
        end
        PhNumber: begin
          if (is_digit(byte_i)) begin
            len_d = len_inc;
          end else if (byte_i == ChQuote) begin
            len_d   = len_inc;
            phase_d = PhBase;
          end else begin
            emit_a  = 1'b1;
            res_a   = mk(K_NUMBER, 8'h00, start_q, sat8(len_q));
            go_idle = 1'b1;
          end
        end
        PhBase: begin
          len_d   = len_inc;
          phase_d = PhLitDig;
          case (byte_i)
            ChB: base_d = 2'd0;
            ChO: base_d = 2'd1;
            ChD: base_d = 2'd2;
            ChH: base_d = 2'd3;
            default: begin
              emit_a  = 1'b1;
              res_a   = mk(K_INVALID, 8'h00, start_q, sat8(len_inc));
              phase_d = PhIdle;
            end
          endcase
        end
        PhLitDig: begin
          if (base_digit(base_q, byte_i)) begin
            len_d = len_inc;
          end else begin
            emit_a  = 1'b1;
            res_a   = mk(K_LITERAL, 8'h00, start_q, sat8(len_q));
            go_idle = 1'b1;
          end
        end
        PhString: begin
          if (byte_i == ChDquote && !esc_q) begin
            emit_a  = 1'b1;
            res_a   = mk(K_STRING, 8'h00, start_q, sat8(len_q));
            phase_d = PhIdle;
          end else begin
            esc_d = !esc_q && (byte_i == ChBslash);
            len_d = len_inc;
          end
        end
        PhOp: begin
          if (pk != K_CHAR) begin
            emit_a  = 1'b1;
            res_a   = mk(pk, 8'h00, start_q, 8'd2);
            phase_d = PhIdle;
          end else begin
            emit_a  = 1'b1;
            res_a   = mk(K_CHAR, fsc_q, start_q, 8'd1);
            go_idle = 1'b1;
          end
        end
        default: go_idle = 1'b1;
      endcase
      // current byte seen from between tokens
      if (go_idle) begin
        phase_d = PhIdle;
        if (!is_space(byte_i)) begin
          if (is_alpha(byte_i) || byte_i == ChUscore) begin
            phase_d = PhIdent;
            start_d = 16'(offset_q);
            len_d   = LenW'(1);
            cand_d  = mask0;
          end else if (is_digit(byte_i)) begin
            phase_d = PhNumber;
            start_d = 16'(offset_q);
            len_d   = LenW'(1);
          end else if (byte_i == ChQuote) begin
            phase_d = PhBase;
            start_d = 16'(offset_q);
            len_d   = LenW'(1);
          end else if (byte_i == ChDquote) begin
            phase_d = PhString;
            start_d = 16'(32'(offset_q) + 32'd1);
            len_d   = '0;
            esc_d   = 1'b0;
          end else if (byte_i == "|" || byte_i == "&" || byte_i == "<" ||
                       byte_i == ">" || byte_i == "=") begin
            phase_d = PhOp;
            start_d = 16'(offset_q);
            len_d   = LenW'(1);
            fsc_d   = byte_i;
          end else begin
            emit_b = 1'b1;
            res_b  = mk(K_CHAR, byte_i, 16'(offset_q), 8'd1);
          end
        end
      end
    end
  end

  always_comb begin
    step_o.cnt = 2'd0;
    step_o.r0  = res_a;
    step_o.r1  = res_b;
    if (fire_i) begin
      if (emit_a && emit_b) begin
        step_o.cnt     = 2'd2;
        step_o.r1.last = 1'b1;
      end else if (emit_a) begin
        step_o.cnt     = 2'd1;
        step_o.r0.last = 1'b1;
      end else if (emit_b) begin
        step_o.cnt     = 2'd1;
        step_o.r0      = res_b;
        step_o.r0.last = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhIdle;
      offset_q <= '0;
      start_q  <= '0;
      len_q    <= '0;
      cand_q   <= '1;
      fsc_q    <= '0;
      base_q   <= '0;
      esc_q    <= 1'b0;
    end else if (fire_i) begin
      phase_q  <= phase_d;
      offset_q <= offset_d;
      start_q  <= start_d;
      len_q    <= len_d;
      cand_q   <= cand_d;
      fsc_q    <= fsc_d;
      base_q   <= base_d;
      esc_q    <= esc_d;
    end
  end

endmodule

### design/hkt_res_fifo.sv
// ---------------------------------------------------------------------------
// hkt_res_fifo
// small result queue, takes up to two tokens per cycle, gives one per cycle unless stalled
// ---------------------------------------------------------------------------
`include "hdl_keyword_tokenizer_macros.svh"

module hkt_res_fifo import hkt_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  step_t push_i,
  output logic  room_o,
  output logic  valid_o,
  input  logic  stall_i,
  output res_t  head_o
);

  localparam int unsigned PtrW = $clog2(FifoDepth);
  localparam int unsigned CntW = $clog2(FifoDepth + 1);

  res_t            mem_q [FifoDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            pop;

  assign valid_o = (cnt_q != '0);
  assign room_o  = (cnt_q <= CntW'(FifoDepth - 2));
  assign pop     = valid_o && !stall_i;
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wr_q] <= push_i.r0;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wr_q + PtrW'(1)] <= push_i.r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + PtrW'(push_i.cnt);
      rd_q  <= rd_q + PtrW'(pop);
      cnt_q <= cnt_q + CntW'(push_i.cnt) - CntW'(pop);
    end
  end

  `HKT_ASSERT(a_push_has_room, (push_i.cnt != 2'd0) |-> room_o, "push without room")
  `HKT_NEVER(a_push_cnt_range, push_i.cnt == 2'd3, "push count out of range")
  `HKT_ASSERT(a_cnt_bound, cnt_q <= CntW'(FifoDepth), "queue count overflow")
  `HKT_ASSERT(a_cnt_hold, (push_i.cnt == 2'd0 && !pop) |=> $stable(cnt_q),
              "queue count moved while idle")

endmodule

### design/hdl_keyword_tokenizer.sv
// path: a byte accepted into the input register is scanned from there, and the tokens
// that it closes are written into the result queue, which offers them at the output
// throughput: one byte per cycle while the result queue has room; one scanner pass per byte sets that figure
// a byte that closes two tokens puts both in the four-entry result queue,
// and the output drains it at one token per cycle while the receiver does not stall
// reset: asynchronous, active low, clears scanner state and queue at once
// ---------------------------------------------------------------------------
// hdl_keyword_tokenizer
// byte stream lexer for a small hdl subset with keyword matching
// ---------------------------------------------------------------------------
module hdl_keyword_tokenizer import hkt_pkg::*; #(
  parameter int unsigned BufferBytes = BufferBytesDef,
  parameter int unsigned MaxTokenLen = MaxTokenLenDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  byte_value_i,
  input  logic        end_of_input_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [4:0]  token_kind_o,
  output logic [7:0]  token_char_o,
  output logic [15:0] token_start_o,
  output logic [7:0]  token_length_o,
  output logic        last_of_run_o
);

  logic       in_valid_q;
  logic [7:0] byte_q;
  logic       eoi_q;
  logic       room;
  logic       fire;
  step_t      step;
  res_t       head;

  assign in_stall_o = in_valid_q && !room;
  assign fire       = in_valid_q && room;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      byte_q <= byte_value_i;
      eoi_q  <= end_of_input_i;
    end
  end

  hkt_lexer #(
    .BufferBytes (BufferBytes),
    .MaxTokenLen (MaxTokenLen)
  ) u_lexer (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .byte_i (byte_q),
    .eoi_i  (eoi_q),
    .step_o (step)
  );

  hkt_res_fifo u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (step),
    .room_o  (room),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .head_o  (head)
  );

  assign token_kind_o   = head.kind;
  assign token_char_o   = head.ch;
  assign token_start_o  = head.start;
  assign token_length_o = head.len;
  assign last_of_run_o  = head.last;

endmodule

### tb/sv/hkt_token_checker.sv
// ---------------------------------------------------------------------------
// hkt_token_checker
// follows both channels of the keyword tokenizer, rebuilds the token stream
// from the accepted bytes and compares every delivered token against it
// ---------------------------------------------------------------------------
module hkt_token_checker import hkt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [7:0]  byte_value_i,
  input  logic        end_of_input_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [4:0]  token_kind_i,
  input  logic [7:0]  token_char_i,
  input  logic [15:0] token_start_i,
  input  logic [7:0]  token_length_i,
  input  logic        last_of_run_i,
  output int          fail_cnt_o,
  output int          pending_o,
  output int          checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [2:0] {
    SCAN_IDLE, SCAN_IDENT, SCAN_NUMBER, SCAN_BASE, SCAN_LITDIG, SCAN_STRING, SCAN_OP
  } scan_phase_e;

  string kw_tab [16] = '{
    "module", "endmodule", "wire", "reg", "always", "initial", "begin", "end",
    "if", "else", "assign", "input", "output", "posedge", "negedge", "or"
  };

  scan_phase_e scan_st;
  logic [16:0] offs;
  logic [15:0] tstart;
  logic [7:0]  tlen;
  logic [15:0] kw_mask;
  logic [7:0]  op_char;
  logic [1:0]  radix;
  logic        esc;

  res_t step_toks [$];
  res_t want_q [$];
  int   fails   = 0;
  int   checked = 0;

  assign fail_cnt_o = fails;
  assign checked_o  = checked;

  function automatic void reset_scan();
    scan_st = SCAN_IDLE;
    offs    = '0;
    tstart  = '0;
    tlen    = '0;
    kw_mask = '1;
    op_char = '0;
    radix   = '0;
    esc     = 1'b0;
  endfunction

  function automatic void put_tok(logic [4:0] kind, logic [7:0] ch, logic [15:0] st,
                                  logic [7:0] ln);
    res_t t;
    if (step_toks.size() < 2) begin
      t.kind  = kind;
      t.ch    = ch;
      t.start = st;
      t.len   = ln;
      t.last  = 1'b0;
      step_toks.push_back(t);
    end
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic void grow_len();
    if (tlen < MaxTokenLenDef) tlen = tlen + 8'd1;
  endfunction

  function automatic void start_tok(scan_phase_e ph, logic [16:0] pos, logic [7:0] ln);
    scan_st = ph;
    tstart  = pos[15:0];
    tlen    = ln;
  endfunction

  // narrow the keyword mask by the character at the current length
  function automatic void ident_char(logic [7:0] c);
    int n;
    n = tlen;
    for (int i = 0; i < NumKw; i++) begin
      if (n >= kw_tab[i].len() || kw_tab[i][n] != c) kw_mask[i] = 1'b0;
    end
    grow_len();
  endfunction

  function automatic void close_ident();
    logic [4:0] kind;
    kind = K_IDENT;
    for (int i = int'(NumKw) - 1; i >= 0; i--) begin
      if (kw_mask[i] && tlen == kw_tab[i].len()) kind = K_KW0 + 5'(i);
    end
    put_tok(kind, 8'd0, tstart, tlen);
  endfunction

  function automatic logic [4:0] pair_kind(logic [7:0] a, logic [7:0] b);
    case ({a, b})
      "||":    return K_LOR;
      "&&":    return K_LAND;
      "<=":    return K_LTE;
      "<<":    return K_LSH;
      ">=":    return K_GTE;
      ">>":    return K_RSH;
      "==":    return K_EQ;
      default: return K_CHAR;
    endcase
  endfunction

  function automatic bit radix_digit(logic [7:0] c);
    case (radix)
      2'd0:    return c == "0" || c == "1";
      2'd1:    return c >= "0" && c <= "7";
      2'd2:    return is_digit(c);
      default: return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endcase
  endfunction

  function automatic void idle_byte(logic [7:0] c, logic [16:0] pos);
    scan_st = SCAN_IDLE;
    if (c == " " || (c >= 8'd9 && c <= 8'd13)) return;
    if (is_alpha(c) || c == "_") begin
      start_tok(SCAN_IDENT, pos, 8'd0);
      kw_mask = '1;
      ident_char(c);
    end else if (is_digit(c)) begin
      start_tok(SCAN_NUMBER, pos, 8'd1);
    end else if (c == "'") begin
      start_tok(SCAN_BASE, pos, 8'd1);
    end else if (c == "\"") begin
      start_tok(SCAN_STRING, pos + 17'd1, 8'd0);
      esc = 1'b0;
    end else if (c == "|" || c == "&" || c == "<" || c == ">" || c == "=") begin
      start_tok(SCAN_OP, pos, 8'd1);
      op_char = c;
    end else begin
      put_tok(K_CHAR, c, pos[15:0], 8'd1);
    end
  endfunction

  function automatic void data_byte(logic [7:0] c, logic [16:0] pos);
    logic [4:0] k;
    case (scan_st)
      SCAN_IDENT: begin
        if (is_alpha(c) || is_digit(c) || c == "_") begin
          ident_char(c);
          return;
        end
        close_ident();
      end
      SCAN_NUMBER: begin
        if (is_digit(c)) begin
          grow_len();
          return;
        end
        if (c == "'") begin
          grow_len();
          scan_st = SCAN_BASE;
          return;
        end
        put_tok(K_NUMBER, 8'd0, tstart, tlen);
      end
      SCAN_BASE: begin
        grow_len();
        case (c)
          "b": radix = 2'd0;
          "o": radix = 2'd1;
          "d": radix = 2'd2;
          "h": radix = 2'd3;
          default: begin
            put_tok(K_INVALID, 8'd0, tstart, tlen);
            scan_st = SCAN_IDLE;
            return;
          end
        endcase
        scan_st = SCAN_LITDIG;
        return;
      end
      SCAN_LITDIG: begin
        if (radix_digit(c)) begin
          grow_len();
          return;
        end
        put_tok(K_LITERAL, 8'd0, tstart, tlen);
      end
      SCAN_STRING: begin
        if (c == "\"" && !esc) begin
          put_tok(K_STRING, 8'd0, tstart, tlen);
          scan_st = SCAN_IDLE;
          return;
        end
        esc = !esc && c == "\\";
        grow_len();
        return;
      end
      SCAN_OP: begin
        k = pair_kind(op_char, c);
        if (k != K_CHAR) begin
          put_tok(k, 8'd0, tstart, 8'd2);
          scan_st = SCAN_IDLE;
          return;
        end
        put_tok(K_CHAR, op_char, tstart, 8'd1);
      end
      default: ;
    endcase
    idle_byte(c, pos);
  endfunction

  function automatic void flush_pending();
    case (scan_st)
      SCAN_IDENT:  close_ident();
      SCAN_NUMBER: put_tok(K_NUMBER, 8'd0, tstart, tlen);
      SCAN_BASE:   put_tok(K_INVALID, 8'd0, tstart, tlen);
      SCAN_LITDIG: put_tok(K_LITERAL, 8'd0, tstart, tlen);
      SCAN_STRING: put_tok(K_STRING, 8'd0, tstart, tlen);
      SCAN_OP:     put_tok(K_CHAR, op_char, tstart, 8'd1);
      default: ;
    endcase
  endfunction

  // tokens completed by one source byte, queued in delivery order
  function automatic void lex_step(logic [7:0] c, logic eoi);
    logic [16:0] pos;
    res_t        t;
    step_toks.delete();
    if (eoi || c == 8'h00 || offs >= BufferBytesDef) begin
      pos = offs;
      flush_pending();
      put_tok(K_EOF, 8'd0, pos[15:0], 8'd0);
      reset_scan();
    end else begin
      data_byte(c, offs);
      offs = offs + 17'd1;
    end
    if (step_toks.size() > 0) begin
      t = step_toks.pop_back();
      t.last = 1'b1;
      step_toks.push_back(t);
    end
    foreach (step_toks[i]) want_q.push_back(step_toks[i]);
  endfunction

  function automatic void log_miss(string why, res_t e, res_t g);
    fails++;
    if (fails <= 10) begin
      $display("%0t %s: expected kind %0d char %02h start %0d len %0d last %0b",
               $time, why, e.kind, e.ch, e.start, e.len, e.last);
      $display("%0t %s: got      kind %0d char %02h start %0d len %0d last %0b",
               $time, why, g.kind, g.ch, g.start, g.len, g.last);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    res_t got;
    res_t exp;
    if (!rst_ni) begin
      reset_scan();
      want_q.delete();
      pending_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        got.kind  = token_kind_i;
        got.ch    = token_char_i;
        got.start = token_start_i;
        got.len   = token_length_i;
        got.last  = last_of_run_i;
        checked++;
        if (want_q.size() == 0) begin
          log_miss("token with none pending", '0, got);
        end else begin
          exp = want_q.pop_front();
          if (got.kind !== exp.kind || got.ch !== exp.ch || got.start !== exp.start ||
              got.len !== exp.len || got.last !== exp.last) begin
            log_miss("token mismatch", exp, got);
          end
        end
      end
      if (in_valid_i && !in_stall_i) lex_step(byte_value_i, end_of_input_i);
      pending_o <= want_q.size();
    end
  end

endmodule

### tb/sv/tb_hdl_keyword_tokenizer.sv
// ---------------------------------------------------------------------------
// tb_hdl_keyword_tokenizer
// feeds the keyword tokenizer directed corner bytes, saturating lengths and
// random source text under four pacing modes; the checker
// beside the block predicts and compares every token
// ---------------------------------------------------------------------------
module tb_hdl_keyword_tokenizer;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        in_valid_i     = 1'b0;
  logic        in_stall_o;
  logic [7:0]  byte_value_i   = 8'd0;
  logic        end_of_input_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i    = 1'b0;
  logic [4:0]  token_kind_o;
  logic [7:0]  token_char_o;
  logic [15:0] token_start_o;
  logic [7:0]  token_length_o;
  logic        last_of_run_o;

  int fail_cnt;
  int pending;
  int checked;

  int   tx_idle_pct  = 0;
  int   rx_stall_pct = 0;
  logic rx_hold      = 1'b0;

  logic [8:0] item_q [$];
  int n_items   = 0;
  int n_ends    = 0;

  string kw_tab [16] = '{
    "module", "endmodule", "wire", "reg", "always", "initial", "begin", "end",
    "if", "else", "assign", "input", "output", "posedge", "negedge", "or"
  };
  string op_tab [7] = '{"||", "&&", "<=", "<<", ">=", ">>", "=="};
  string op_first   = "|&<>=";
  string base_tab   = "bodh";
  string hex_tab    = "0123456789abcdefABCDEF";
  string punct_tab  = ";,()[]{}+-*/#@.:!~^?%$";

  hdl_keyword_tokenizer uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .byte_value_i   (byte_value_i),
    .end_of_input_i (end_of_input_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .token_kind_o   (token_kind_o),
    .token_char_o   (token_char_o),
    .token_start_o  (token_start_o),
    .token_length_o (token_length_o),
    .last_of_run_o  (last_of_run_o)
  );

  hkt_token_checker u_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .byte_value_i   (byte_value_i),
    .end_of_input_i (end_of_input_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .token_kind_i   (token_kind_o),
    .token_char_i   (token_char_o),
    .token_start_i  (token_start_o),
    .token_length_i (token_length_o),
    .last_of_run_i  (last_of_run_o),
    .fail_cnt_o     (fail_cnt),
    .pending_o      (pending),
    .checked_o      (checked)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= rx_hold || ($urandom_range(99) < rx_stall_pct);
    end
  end

  initial begin
    #10_000_000;
    $display("FAIL");
    $finish;
  end

  task automatic hold_receiver(int cycles);
    rx_hold <= 1'b1;
    repeat (cycles) @(posedge clk_i);
    rx_hold <= 1'b0;
  endtask

  task automatic push_item(logic [7:0] b, logic eoi);
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    byte_value_i   <= b;
    end_of_input_i <= eoi;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    n_items++;
    if (eoi || b == 8'h00) n_ends++;
  endtask

  task automatic send_queued();
    logic [8:0] v;
    while (item_q.size() != 0) begin
      v = item_q.pop_front();
      push_item(v[7:0], v[8]);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  function automatic void add_byte(logic [7:0] b);
    item_q.push_back({1'b0, b});
  endfunction

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endfunction

  function automatic void add_end();
    if ($urandom_range(1)) item_q.push_back({1'b1, 8'($urandom_range(255))});
    else item_q.push_back({1'b0, 8'h00});
  endfunction

  function automatic logic [7:0] ident_byte();
    int k;
    k = $urandom_range(62);
    if (k < 26) return 8'("a" + k);
    if (k < 52) return 8'("A" + k - 26);
    if (k < 62) return 8'("0" + k - 52);
    return "_";
  endfunction

  // one random lexeme followed by an optional separator, never a nul
  function automatic void add_lexeme();
    string       w;
    logic [7:0]  c;
    int          k;
    case ($urandom_range(11))
      0: add_text(kw_tab[$urandom_range(15)]);
      1: begin
        w = kw_tab[$urandom_range(15)];
        if ($urandom_range(1)) begin
          for (int i = 0; i < w.len() - 1; i++) add_byte(w[i]);
        end else begin
          add_text(w);
          add_byte(ident_byte());
        end
      end
      2: begin
        c = ident_byte();
        if (c >= "0" && c <= "9") c = "_";
        add_byte(c);
        repeat ($urandom_range(7)) add_byte(ident_byte());
      end
      3: repeat ($urandom_range(1, 5)) add_byte(8'("0" + $urandom_range(9)));
      4: begin
        repeat ($urandom_range(2)) add_byte(8'("0" + $urandom_range(9)));
        add_byte("'");
        add_byte(base_tab[$urandom_range(3)]);
        repeat ($urandom_range(1, 6)) add_byte(hex_tab[$urandom_range(21)]);
      end
      5: begin
        add_byte("'");
        do c = 8'($urandom_range(1, 255)); while (c == "b" || c == "o" || c == "d" || c == "h");
        add_byte(c);
      end
      6: begin
        add_byte("\"");
        repeat ($urandom_range(8)) begin
          k = $urandom_range(9);
          if (k == 0) begin
            add_text("\\\"");
          end else if (k == 1) begin
            add_text("\\\\");
          end else if (k == 2) begin
            add_byte(8'($urandom_range(128, 255)));
          end else begin
            c = 8'($urandom_range(32, 126));
            if (c == "\"" || c == "\\") c = "x";
            add_byte(c);
          end
        end
        if ($urandom_range(7) != 0) add_byte("\"");
      end
      7: add_text(op_tab[$urandom_range(6)]);
      8: add_byte(op_first[$urandom_range(4)]);
      9: add_byte(punct_tab[$urandom_range(punct_tab.len() - 1)]);
      10: begin
        if ($urandom_range(1)) add_byte(8'($urandom_range(128, 255)));
        else add_byte(8'($urandom_range(1, 31)));
      end
      default: repeat ($urandom_range(1, 4)) add_byte(8'($urandom_range(1, 255)));
    endcase
    k = $urandom_range(9);
    if (k >= 3 && k <= 6) add_byte(" ");
    else if (k == 7) add_byte(8'($urandom_range(9, 13)));
    else if (k >= 8) add_text("  ");
  endfunction

  task automatic run_phase(int tx, int rx, int count, bit with_hold);
    int target;
    tx_idle_pct  = tx;
    rx_stall_pct = rx;
    if (with_hold) begin
      fork
        hold_receiver(80);
      join_none
    end
    target = n_items + count;
    while (n_items < target) begin
      add_lexeme();
      if ($urandom_range(29) == 0) add_end();
      send_queued();
    end
    drain();
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // bad base letter, end after quote, escapes, high bytes, ops, open string, repeated end
    add_text("'q");
    add_text("7'");
    item_q.push_back({1'b1, 8'hff});
    add_text("\"\\\\\"");
    add_byte(8'hff);
    add_byte(8'h80);
    add_text("if||>=");
    add_text("\"a");
    add_byte(8'h00);
    item_q.push_back({1'b1, 8'h00});
    item_q.push_back({1'b1, 8'h5a});
    send_queued();
    drain();

    // saturating lengths on an identifier and a string
    repeat (300) add_byte("a");
    add_byte(" ");
    add_byte("\"");
    repeat (300) add_byte(8'($urandom_range(35, 91)));
    add_byte("\"");
    add_end();
    send_queued();
    drain();

    run_phase(0, 0, 150, 1'b1);
    run_phase(60, 0, 150, 1'b0);
    run_phase(0, 60, 150, 1'b0);
    run_phase(16, 16, 150, 1'b0);

    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    add_end();
    send_queued();
    drain();
    repeat (20) @(posedge clk_i);

    $display("sent %0d source bytes with %0d end markers, checked %0d tokens",
             n_items, n_ends, checked);
    $display("pacing: free flow, sender gaps, receiver stalls, both, long receiver hold");
    if (fail_cnt == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+design
design/hkt_pkg.sv
design/hkt_lexer.sv
design/hkt_res_fifo.sv
design/hdl_keyword_tokenizer.sv
tb/sv/hkt_token_checker.sv
tb/sv/tb_hdl_keyword_tokenizer.sv
